// ----- rtl/iir_first_order_lookahead_filter_core_macros.svh -----
// Assertion macros used by the checker file of the look-ahead IIR filter.
`ifndef IIR_FIRST_ORDER_LOOKAHEAD_FILTER_CORE_MACROS_SVH
`define IIR_FIRST_ORDER_LOOKAHEAD_FILTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IIRLA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted.
`define IIRLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: label");

`endif

// ----- rtl/iirla_pkg.sv -----
// Package with widths, register codes and control types of the look-ahead IIR filter.
`timescale 1ns / 1ps

package iirla_pkg;

	// Sample and arithmetic widths.
	localparam int DATA_BITS = 8;
	localparam int IN_BITS   = DATA_BITS;
	localparam int COEF_BITS = 8;
	localparam int W_BITS    = 12;
	localparam int OUT_BITS  = 14;
	localparam int SHIFT_AMT = DATA_BITS + 1;
	localparam int PROD_BITS = W_BITS + COEF_BITS;
	localparam int ACC_BITS  = OUT_BITS - 2;
	localparam int CFG_IDX_BITS = 3;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_B0 = 3'd0,
		REG_B1 = 3'd1,
		REG_B2 = 3'd2,
		REG_B3 = 3'd3,
		REG_A1 = 3'd4
	} reg_idx_t;

	// Reset values of the coefficients.
	localparam logic signed [COEF_BITS-1:0] RST_B0 = COEF_BITS'(53);
	localparam logic signed [COEF_BITS-1:0] RST_B1 = COEF_BITS'(53);
	localparam logic signed [COEF_BITS-1:0] RST_B2 = COEF_BITS'(-9);
	localparam logic signed [COEF_BITS-1:0] RST_B3 = COEF_BITS'(-9);
	localparam logic signed [COEF_BITS-1:0] RST_A1 = COEF_BITS'(3);

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FB,
		ST_WCALC,
		ST_P0,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_FIN
	} st_t;

	// Operand pairs for the shared multiplier.
	typedef enum logic [2:0] {
		MS_D2_A1,
		MS_W_B0,
		MS_D1_B1,
		MS_D1_B2,
		MS_D2_B3
	} mul_sel_t;

	// Accumulator operations.
	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_CLR,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	// Control word from the sequencer to the datapath.
	typedef struct packed {
		logic     in_ready;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     w_load;
		acc_op_t  acc_op;
		logic     fin;
	} ctrl_t;

endpackage

// ----- rtl/iirla_mul.sv -----
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module iirla_mul (
	input  logic                                    clk,
	input  logic                                    en,
	input  logic signed [iirla_pkg::W_BITS-1:0]     op_a,
	input  logic signed [iirla_pkg::COEF_BITS-1:0]  op_b,
	output logic signed [iirla_pkg::PROD_BITS-1:0]  prod
);
	import iirla_pkg::*;

	logic signed [PROD_BITS-1:0] prod_q;

	// Full-precision product, captured when the sequencer issues an operation.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PROD_BITS'(op_a) * PROD_BITS'(op_b);
		end
	end

	assign prod = prod_q;

endmodule

// ----- rtl/iirla_seq.sv -----
// Sequencer that steps the shared multiplier through the five products of one item.
`timescale 1ns / 1ps

module iirla_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             out_free,
	output iirla_pkg::ctrl_t ctrl
);
	import iirla_pkg::*;

	st_t state_q;
	st_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and control word.
	always_comb begin
		state_next    = state_q;
		ctrl.in_ready = 1'b0;
		ctrl.mul_en   = 1'b0;
		ctrl.mul_sel  = MS_D2_A1;
		ctrl.w_load   = 1'b0;
		ctrl.acc_op   = ACC_HOLD;
		ctrl.fin      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.in_ready = 1'b1;
				if (in_valid) begin
					state_next = ST_FB;
				end
			end
			ST_FB: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MS_D2_A1;
				state_next   = ST_WCALC;
			end
			ST_WCALC: begin
				ctrl.w_load = 1'b1;
				ctrl.acc_op = ACC_CLR;
				state_next  = ST_P0;
			end
			ST_P0: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MS_W_B0;
				state_next   = ST_P1;
			end
			ST_P1: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MS_D1_B1;
				ctrl.acc_op  = ACC_ADD;
				state_next   = ST_P2;
			end
			ST_P2: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MS_D1_B2;
				ctrl.acc_op  = ACC_ADD;
				state_next   = ST_P3;
			end
			ST_P3: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MS_D2_B3;
				ctrl.acc_op  = ACC_SUB;
				state_next   = ST_FIN;
			end
			ST_FIN: begin
				// Wait here until the output register is free.
				if (out_free) begin
					ctrl.fin   = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/iir_first_order_lookahead_filter_core.sv -----
// Top level of the first-order look-ahead IIR filter with one shared multiplier.
//
//  channel   | signals                          | direction
//  ----------+----------------------------------+----------
//  input     | in_valid, in_ready, sample_in    | in
//  output    | out_valid, out_ready, sample_out | out
//  config    | cfg_we, cfg_index, cfg_data      | in
//
// Each item passes through one accept step and seven sequencer steps, set by the
// five products that share the one multiplier plus the w and finish steps.
// The item is only finished once the output register is free, so a stalled output
// holds the sequencer in its last step.
// Reset restores the coefficient defaults and clears both delay values.
`timescale 1ns / 1ps

module iir_first_order_lookahead_filter_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [iirla_pkg::IN_BITS-1:0]    sample_in,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [iirla_pkg::OUT_BITS-1:0]   sample_out,
	input  logic                                    cfg_we,
	input  logic [iirla_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [iirla_pkg::COEF_BITS-1:0]         cfg_data
);
	import iirla_pkg::*;

	ctrl_t ctrl;

	logic signed [COEF_BITS-1:0] b0_q, b1_q, b2_q, b3_q, a1_q;
	logic signed [IN_BITS-1:0]   x_q;
	logic signed [W_BITS-1:0]    w_q, d1_q, d2_q;
	logic signed [ACC_BITS-1:0]  acc_q;
	logic signed [OUT_BITS-1:0]  out_q;
	logic                        out_valid_q;

	logic signed [W_BITS-1:0]    op_a;
	logic signed [COEF_BITS-1:0] op_b;
	logic signed [PROD_BITS-1:0] prod;
	logic signed [PROD_BITS-1:0] prod_sh;
	logic signed [ACC_BITS-1:0]  term;
	logic signed [ACC_BITS-1:0]  acc_fin;
	logic                        out_free;

	// Coefficient registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= RST_B0;
			b1_q <= RST_B1;
			b2_q <= RST_B2;
			b3_q <= RST_B3;
			a1_q <= RST_A1;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_B0:  b0_q <= cfg_data;
				REG_B1:  b1_q <= cfg_data;
				REG_B2:  b2_q <= cfg_data;
				REG_B3:  b3_q <= cfg_data;
				REG_A1:  a1_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = ctrl.in_ready;
	assign out_free = !out_valid_q || out_ready;

	iirla_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (ctrl.mul_sel)
			MS_D2_A1: begin op_a = d2_q; op_b = a1_q; end
			MS_W_B0:  begin op_a = w_q;  op_b = b0_q; end
			MS_D1_B1: begin op_a = d1_q; op_b = b1_q; end
			MS_D1_B2: begin op_a = d1_q; op_b = b2_q; end
			MS_D2_B3: begin op_a = d2_q; op_b = b3_q; end
			default:  begin op_a = d2_q; op_b = a1_q; end
		endcase
	end

	iirla_mul u_mul (
		.clk  (clk),
		.en   (ctrl.mul_en),
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod)
	);

	// Arithmetic shift of the product; only the low bits survive the wrap.
	assign prod_sh = prod >>> SHIFT_AMT;
	assign term    = prod_sh[ACC_BITS-1:0];
	assign acc_fin = acc_q - term;

	// Input sample capture.
	always_ff @(posedge clk) begin
		if (in_valid && ctrl.in_ready) begin
			x_q <= sample_in;
		end
	end

	// Intermediate value and the accumulator of the feedforward terms.
	always_ff @(posedge clk) begin
		if (ctrl.w_load) begin
			w_q <= W_BITS'(x_q) - prod_sh[W_BITS-1:0];
		end
		unique case (ctrl.acc_op)
			ACC_CLR:  acc_q <= '0;
			ACC_ADD:  acc_q <= acc_q + term;
			ACC_SUB:  acc_q <= acc_q - term;
			default:  ;
		endcase
	end

	// Delay line of the intermediate value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else if (ctrl.fin) begin
			d2_q <= d1_q;
			d1_q <= w_q;
		end
	end

	// Output register; the sum is scaled by four.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fin) begin
			out_q <= {acc_fin, 2'b00};
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

endmodule

// ----- rtl/iirla_checker.sv -----
// Port-level checker of the look-ahead IIR filter and its bind to the top level.
`timescale 1ns / 1ps
`include "iir_first_order_lookahead_filter_core_macros.svh"

module iirla_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [iirla_pkg::OUT_BITS-1:0] sample_out
);
	import iirla_pkg::*;

	logic in_acc;
	logic out_stall;
	assign in_acc    = in_valid && in_ready;
	assign out_stall = out_valid && !out_ready;

	// A result waiting at a stalled output keeps its value.
	`IIRLA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, out_valid && $stable(sample_out))
	// The block is busy in the cycle after it takes an item.
	`IIRLA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_acc, !in_ready)
	// The block is still busy when its sequencer reaches the last product step of an item.
	`IIRLA_ASSERT_NEXT(a_busy_span, clk, arst_n, in_acc, ##5 !in_ready)
	// A new result appears exactly as the block turns ready again.
	`IIRLA_ASSERT_IMPL(a_result_frees, clk, arst_n, $rose(out_valid), in_ready && !$past(in_ready))

endmodule

bind iir_first_order_lookahead_filter_core iirla_checker u_iirla_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.sample_out (sample_out)
);
